// ----- rtl/tgp_pkg.sv -----
// shared types and command codes for the turtle grid plotter
`default_nettype none

package tgp_pkg;

	localparam logic [3:0] CMD_PEN_UP   = 4'd1;
	localparam logic [3:0] CMD_PEN_DOWN = 4'd2;
	localparam logic [3:0] CMD_RIGHT    = 4'd3;
	localparam logic [3:0] CMD_LEFT     = 4'd4;
	localparam logic [3:0] CMD_FORWARD  = 4'd5;
	localparam logic [3:0] CMD_READ     = 4'd6;
	localparam logic [3:0] CMD_RESTART  = 4'd7;
	localparam logic [3:0] CMD_STOP     = 4'd9;

	localparam logic [1:0] HEAD_NORTH = 2'd0;
	localparam logic [1:0] HEAD_EAST  = 2'd1;
	localparam logic [1:0] HEAD_SOUTH = 2'd2;
	localparam logic [1:0] HEAD_WEST  = 2'd3;

	localparam logic signed [15:0] POS_MAX = 16'sh7fff;
	localparam logic signed [15:0] POS_MIN = -16'sh8000;

	typedef struct packed {
		logic              halted;
		logic              pen_is_down;
		logic [1:0]        heading;
		logic signed [15:0] pos_col;
		logic signed [15:0] pos_row;
		logic              cell_value;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/tgp_grid_mem.sv -----
// grid bit memory with registered read and a clearing sweep
`default_nettype none

module tgp_grid_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr_start,
	output logic               clr_busy,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic          mem [DEPTH];
	logic          busy_q;
	logic [AW-1:0] clr_q;
	logic          rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (clr_start) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (we) begin
			mem[waddr] <= 1'b1;
		end
		rdata_q <= mem[raddr];
	end

	assign clr_busy = busy_q;
	assign rdata    = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/tgp_seq.sv -----
// command sequencer: turtle state, step datapath and grid access
`default_nettype none

module tgp_seq #(
	parameter int GRID_SIZE = 64,
	parameter int MAX_STEPS = 100,
	parameter int AW        = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire logic [3:0]    mode,
	input  wire logic [6:0]    steps,
	input  wire logic [5:0]    query_row,
	input  wire logic [5:0]    query_col,
	output logic               res_valid,
	input  wire logic          res_ready,
	output tgp_pkg::result_t   res,
	output logic               clr_start,
	input  wire logic          clr_busy,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [AW-1:0]      mem_raddr,
	input  wire logic          mem_rdata
);

	localparam int RW = $clog2(GRID_SIZE);
	localparam int CW = $clog2(MAX_STEPS + 1);
	localparam int SW = ((CW + 1 > 16) ? CW + 1 : 16) + 1;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic signed [15:0] row_q;
	logic signed [15:0] col_q;
	logic [1:0]         head_q;
	logic               pen_q;
	logic               halt_q;
	logic               cell_q;
	logic [CW-1:0]      cnt_q;

	logic               accept;
	logic [CW-1:0]      steps_c;
	logic [CW-1:0]      mag;
	logic signed [SW-1:0] mag_w;
	logic signed [SW-1:0] row_sum;
	logic signed [SW-1:0] col_sum;
	logic signed [15:0] row_nxt;
	logic signed [15:0] col_nxt;
	logic               nxt_on_grid;
	logic               q_on_grid;

	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign cmd_ready = (state_q == ST_IDLE);

	assign steps_c = (32'(steps) > MAX_STEPS) ? CW'(MAX_STEPS) : CW'(steps);
	assign mag     = (state_q == ST_WALK) ? CW'(1) : steps_c;
	assign mag_w   = signed'({{(SW - CW){1'b0}}, mag});

	// one axis moves, the other keeps its value
	always_comb begin
		row_sum = {{(SW - 16){row_q[15]}}, row_q};
		col_sum = {{(SW - 16){col_q[15]}}, col_q};
		unique case (head_q)
			tgp_pkg::HEAD_NORTH: row_sum = row_sum - mag_w;
			tgp_pkg::HEAD_SOUTH: row_sum = row_sum + mag_w;
			tgp_pkg::HEAD_EAST:  col_sum = col_sum + mag_w;
			default:             col_sum = col_sum - mag_w;
		endcase
	end

	always_comb begin
		if (row_sum > SW'(tgp_pkg::POS_MAX)) begin
			row_nxt = tgp_pkg::POS_MAX;
		end else if (row_sum < SW'(tgp_pkg::POS_MIN)) begin
			row_nxt = tgp_pkg::POS_MIN;
		end else begin
			row_nxt = row_sum[15:0];
		end
		if (col_sum > SW'(tgp_pkg::POS_MAX)) begin
			col_nxt = tgp_pkg::POS_MAX;
		end else if (col_sum < SW'(tgp_pkg::POS_MIN)) begin
			col_nxt = tgp_pkg::POS_MIN;
		end else begin
			col_nxt = col_sum[15:0];
		end
	end

	assign nxt_on_grid = !row_nxt[15] && !col_nxt[15]
		&& (unsigned'(row_nxt) < 16'(GRID_SIZE))
		&& (unsigned'(col_nxt) < 16'(GRID_SIZE));
	assign q_on_grid = ({10'd0, query_row} < 16'(GRID_SIZE))
		&& ({10'd0, query_col} < 16'(GRID_SIZE));

	assign mem_we    = (state_q == ST_WALK) && nxt_on_grid;
	assign mem_waddr = AW'(row_nxt[RW-1:0]) * AW'(GRID_SIZE) + AW'(col_nxt[RW-1:0]);
	assign mem_raddr = AW'(RW'(query_row)) * AW'(GRID_SIZE) + AW'(RW'(query_col));

	assign clr_start = accept && (mode == tgp_pkg::CMD_RESTART);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			row_q   <= '0;
			col_q   <= '0;
			head_q  <= tgp_pkg::HEAD_EAST;
			pen_q   <= 1'b0;
			halt_q  <= 1'b0;
			cell_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (!clr_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cell_q  <= 1'b0;
						state_q <= ST_DONE;
						priority if (mode == tgp_pkg::CMD_RESTART) begin
							row_q   <= '0;
							col_q   <= '0;
							head_q  <= tgp_pkg::HEAD_EAST;
							pen_q   <= 1'b0;
							halt_q  <= 1'b0;
							state_q <= ST_CLEAR;
						end else if (mode == tgp_pkg::CMD_READ) begin
							if (q_on_grid) begin
								state_q <= ST_READ;
							end
						end else if (!halt_q) begin
							unique case (mode)
								tgp_pkg::CMD_PEN_UP:   pen_q  <= 1'b0;
								tgp_pkg::CMD_PEN_DOWN: pen_q  <= 1'b1;
								tgp_pkg::CMD_RIGHT:    head_q <= head_q + 2'd1;
								tgp_pkg::CMD_LEFT:     head_q <= head_q - 2'd1;
								tgp_pkg::CMD_STOP:     halt_q <= 1'b1;
								tgp_pkg::CMD_FORWARD: begin
									if (steps_c != '0) begin
										if (pen_q) begin
											cnt_q   <= steps_c;
											state_q <= ST_WALK;
										end else begin
											row_q <= row_nxt;
											col_q <= col_nxt;
										end
									end
								end
								default: ;
							endcase
						end else begin
						end
					end
				end
				ST_WALK: begin
					row_q <= row_nxt;
					col_q <= col_nxt;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					cell_q  <= mem_rdata;
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (!clr_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid       = (state_q == ST_DONE);
	assign res.halted      = halt_q;
	assign res.pen_is_down = pen_q;
	assign res.heading     = head_q;
	assign res.pos_col     = col_q;
	assign res.pos_row     = row_q;
	assign res.cell_value  = cell_q;

endmodule

`default_nettype wire

// ----- rtl/turtle_grid_plotter_unit.sv -----
// top level of the turtle grid plotter: stream ports, result register, checks
// from accept to m_tvalid: every command passes the done state and then the result register;
// read of an on-grid cell adds the read state; forward with pen down adds the walk state, one write per on-grid step;
// restart adds the clear state, which waits for the one-cell-per-cycle clearing sweep
// throughput: one command at a time; a new one is taken while the last result waits in the output register
// reset: turtle state to home, facing east, pen up; s_tready stays low for the
// clearing sweep that follows reset
`default_nettype none

module turtle_grid_plotter_unit #(
	parameter int GRID_SIZE = 64,
	parameter int MAX_STEPS = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // steps, query_row, query_col
	input  wire logic [3:0]  s_tuser,  // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // cell_value, pos_row, pos_col, heading, pen_is_down, halted
);

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);

	logic             res_valid;
	logic             res_ready;
	tgp_pkg::result_t res;
	logic             clr_start;
	logic             clr_busy;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	logic             mem_rdata;
	logic             m_valid_q;
	tgp_pkg::result_t res_q;

	tgp_seq #(
		.GRID_SIZE(GRID_SIZE),
		.MAX_STEPS(MAX_STEPS),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(s_tvalid),
		.cmd_ready(s_tready),
		.mode(s_tuser),
		.steps(s_tdata[6:0]),
		.query_row(s_tdata[12:7]),
		.query_col(s_tdata[18:13]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.clr_start(clr_start),
		.clr_busy(clr_busy),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	tgp_grid_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.clr_start(clr_start),
		.clr_busy(clr_busy),
		.we(mem_we),
		.waddr(mem_waddr),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, res_q};

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && clr_busy))
		else $error("command beat taken during grid clear");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && clr_busy))
		else $error("grid write during clearing sweep");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("pending result dropped or changed");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_start |=> clr_busy && !s_tready)
		else $error("restart did not start clearing sweep");

endmodule

`default_nettype wire
